>>> src/c5cf_pkg.sv
package c5cf_pkg;

  // frame geometry
  localparam int IMAGE_COLUMNS = 256;
  localparam int IMAGE_ROWS    = 256;
  localparam int COL_W         = $clog2(IMAGE_COLUMNS);
  localparam int ROW_W         = $clog2(IMAGE_ROWS);

  // window and kernel
  localparam int PIX_W     = 8;
  localparam int KSIZE     = 5;
  localparam int LINES     = KSIZE - 1;
  localparam int COEF_W    = 8;
  localparam int KROW_W    = KSIZE * COEF_W;
  localparam int CFG_IDX_W = 3;

  // accumulation widths
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int RSUM_W = PROD_W + 3;
  localparam int SUM_W  = RSUM_W + 3;

  // divide by the tap count through a reciprocal, valid below the clamp limit
  localparam int DIV_N       = KSIZE * KSIZE;
  localparam int PIX_MAX     = (1 << PIX_W) - 1;
  localparam int CLAMP_LIMIT = DIV_N * (1 << PIX_W);
  localparam int QIN_W       = $clog2(CLAMP_LIMIT);
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + DIV_N - 1) / DIV_N;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int QMUL_W      = QIN_W + RECIP_W;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [LINES-1:0] line_word_t;
  typedef pix_t [KSIZE-1:0][KSIZE-1:0] window_t;
  typedef logic [KSIZE-1:0][KSIZE-1:0][COEF_W-1:0] kernel_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // travels with an item down the arithmetic stages
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KROW0 = 3'd0,
    REG_KROW1 = 3'd1,
    REG_KROW2 = 3'd2,
    REG_KROW3 = 3'd3,
    REG_KROW4 = 3'd4
  } cfg_reg_e;

endpackage

>>> src/conv5x5_clamp_filter_top.sv
// 5x5 convolution filter for 8-bit grey pixels, 256 x 256 frame, raster order.
// input channel: in_valid_i / in_stall_o carry one pixel beat (pixel_in_i,
//   frame_start_i); frame_start_i marks row 0, column 0 and resets position.
// output channel: out_valid_o / out_stall_i carry one result beat for every
//   pixel at row >= 4 and column >= 4; the result is for the window center
//   two rows up and two columns left; frame_last_o flags the last one.
// kernel: five 40-bit rows written through cfg_we_i / cfg_index_i /
//   cfg_data_i while idle, byte x of row y is signed coefficient (y, x);
//   indexes above four are ignored.
// result: sum of the 25 products, floor-divided by 25, clamped to 0..255.
// throughput: one pixel per cycle while in_stall_o is low; a pixel passes the
//   line store read, window, product, row sum, total and output registers.
// reset: position counters and kernel clear; line store holds stale data that
//   no result ever reads, so no clearing pass is needed.
// stall: the output register holds its beat; the pipe keeps taking pixels
//   while the beat about to reach the output is a bubble, otherwise it stops
//   and in_stall_o rises.
module conv5x5_clamp_filter_top
  import c5cf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 frame_start_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     filtered_pixel_o,
  output logic                 frame_last_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KROW_W-1:0]    cfg_data_i
);

  // kernel registers
  logic [KSIZE-1:0][KROW_W-1:0] krow_q;
  kernel_t                      kernel;

  // position and stage 1 (line store read in flight)
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic             s1_last_q;
  logic [COL_W-1:0] s1_col_q;
  pix_t             s1_pix_q;

  // window and arithmetic
  window_t    window_q, window_d;
  line_word_t rd_word, wr_word;
  pix_t [KSIZE-1:0] column;
  tag_t       s2_tag_q, mac_tag;
  pix_t       mac_result;

  // output register
  logic out_valid_q;
  logic out_last_q;
  pix_t out_pix_q;

  logic en;
  logic in_accept;

  // pipe advances unless a real result would run into a stalled full output
  assign en         = !(out_valid_q && out_stall_i && mac_tag.valid);
  assign in_stall_o = !en;
  assign in_accept  = in_valid_i && en;

  // kernel write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      krow_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KROW0: krow_q[0] <= cfg_data_i;
        REG_KROW1: krow_q[1] <= cfg_data_i;
        REG_KROW2: krow_q[2] <= cfg_data_i;
        REG_KROW3: krow_q[3] <= cfg_data_i;
        REG_KROW4: krow_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign kernel = kernel_t'(krow_q);

  // position of the incoming pixel, with frame start taking precedence
  always_comb begin
    row_cur = frame_start_i ? '0 : row_q;
    col_cur = frame_start_i ? '0 : col_q;
    if (col_cur == COL_W'(IMAGE_COLUMNS - 1)) begin
      col_d = '0;
      row_d = (row_cur == ROW_W'(IMAGE_ROWS - 1)) ? '0 : row_cur + 1'b1;
    end else begin
      col_d = col_cur + 1'b1;
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_accept;
      s1_emit_q  <= in_accept && (row_cur >= ROW_W'(LINES)) && (col_cur >= COL_W'(LINES));
      s1_last_q  <= (row_cur == ROW_W'(IMAGE_ROWS - 1))
                 && (col_cur == COL_W'(IMAGE_COLUMNS - 1));
      if (in_accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_col_q <= col_cur;
      s1_pix_q <= pixel_in_i;
    end
  end

  // line store: read at accept, shift the column and write back from stage 1
  c5cf_line_mem u_line_mem (
    .clk_i     (clk_i),
    .en_i      (en),
    .rd_addr_i (col_cur),
    .wr_en_i   (en && s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // column top to bottom: oldest line first, new pixel last
  always_comb begin
    for (int y = 0; y < LINES; y++) begin
      column[y] = rd_word[LINES-1-y];
    end
    column[KSIZE-1] = s1_pix_q;
    wr_word[0] = s1_pix_q;
    for (int i = 1; i < LINES; i++) begin
      wr_word[i] = rd_word[i-1];
    end
    for (int y = 0; y < KSIZE; y++) begin
      for (int x = 0; x < KSIZE - 1; x++) begin
        window_d[y][x] = window_q[y][x+1];
      end
      window_d[y][KSIZE-1] = column[y];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tag_q <= '0;
    end else if (en) begin
      s2_tag_q.valid <= s1_valid_q && s1_emit_q;
      s2_tag_q.last  <= s1_valid_q && s1_emit_q && s1_last_q;
    end
  end

  c5cf_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .tag_i    (s2_tag_q),
    .window_i (window_q),
    .kernel_i (kernel),
    .tag_o    (mac_tag),
    .result_o (mac_result)
  );

  // output register, loads whenever it is empty or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= mac_tag.valid;
      out_last_q  <= mac_tag.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_pix_q <= mac_result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_pixel_o = out_pix_q;
  assign frame_last_o     = out_last_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && mac_tag.valid |-> in_stall_o)
    else $error("result would overwrite a stalled output beat");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_W'(IMAGE_COLUMNS - 1)) && (row_q <= ROW_W'(IMAGE_ROWS - 1)))
    else $error("position counter out of frame");

  a_emit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q |-> s1_col_q >= COL_W'(LINES))
    else $error("result raised for a border column");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(s1_valid_q) && $stable(s2_tag_q))
    else $error("front stages moved while held");

endmodule

>>> src/c5cf_line_mem.sv
module c5cf_line_mem
  import c5cf_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  line_word_t       wr_data_i,
  output line_word_t       rd_data_o
);

  // four lines side by side, one column per entry
  line_word_t mem [IMAGE_COLUMNS];
  line_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // write to the address being read wins over the old entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

  // lines not yet filled read as unknown, so compare with case equality
  a_fwd: assert property (@(posedge clk_i)
    en_i && wr_en_i && (wr_addr_i == rd_addr_i) |=> rd_data_o === $past(wr_data_i))
    else $error("line store forwarding missed");

  a_hold: assert property (@(posedge clk_i)
    !en_i |=> $stable(rd_data_o))
    else $error("line store read data moved while held");

  a_rd: assert property (@(posedge clk_i)
    en_i && !(wr_en_i && (wr_addr_i == rd_addr_i)) |=> rd_data_o === $past(mem[rd_addr_i]))
    else $error("line store read data wrong");

endmodule

>>> src/c5cf_mac.sv
module c5cf_mac
  import c5cf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  tag_t    tag_i,
  input  window_t window_i,
  input  kernel_t kernel_i,
  output tag_t    tag_o,
  output pix_t    result_o
);

  prod_t [KSIZE-1:0][KSIZE-1:0] prod_d, prod_q;
  rsum_t [KSIZE-1:0]            rsum_d, rsum_q;
  sum_t                         sum_d, sum_q;
  tag_t                         prod_tag_q, rsum_tag_q, sum_tag_q;
  logic  [QIN_W-1:0]            qin;
  logic  [QMUL_W-1:0]           qmul;

  // 25 products, then row sums, then the total
  always_comb begin
    for (int y = 0; y < KSIZE; y++) begin
      for (int x = 0; x < KSIZE; x++) begin
        prod_d[y][x] = PROD_W'($signed(kernel_i[y][x]))
                     * PROD_W'($signed({1'b0, window_i[y][x]}));
      end
    end
    for (int y = 0; y < KSIZE; y++) begin
      rsum_d[y] = '0;
      for (int x = 0; x < KSIZE; x++) begin
        rsum_d[y] = rsum_d[y] + RSUM_W'(prod_q[y][x]);
      end
    end
    sum_d = '0;
    for (int y = 0; y < KSIZE; y++) begin
      sum_d = sum_d + SUM_W'(rsum_q[y]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_tag_q <= '0;
      rsum_tag_q <= '0;
      sum_tag_q  <= '0;
    end else if (en_i) begin
      prod_tag_q <= tag_i;
      rsum_tag_q <= prod_tag_q;
      sum_tag_q  <= rsum_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      rsum_q <= rsum_d;
      sum_q  <= sum_d;
    end
  end

  // floor divide by the tap count, only used below the clamp limit
  assign qin  = sum_q[QIN_W-1:0];
  assign qmul = QMUL_W'(qin) * QMUL_W'(RECIP);

  always_comb begin
    if (sum_q < 0) begin
      result_o = '0;
    end else if (sum_q >= SUM_W'(CLAMP_LIMIT)) begin
      result_o = PIX_W'(PIX_MAX);
    end else begin
      result_o = qmul[RECIP_SHIFT +: PIX_W];
    end
  end

  assign tag_o = sum_tag_q;

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_o.last |-> tag_o.valid)
    else $error("last flag on an empty stage");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(tag_o) && $stable(sum_q))
    else $error("arithmetic stage moved while held");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && rsum_tag_q.valid |=> tag_o.valid)
    else $error("item dropped between row sum and total");

endmodule
